FILE: src/pcmt_pkg.sv
// types and constants shared by the pending command match table
package pcmt_pkg;

   localparam int SLOT_W       = 3;
   localparam int SHORT_ADDR_W = 16;

   typedef enum logic [1:0] {
      CMD_FIND   = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

   typedef struct packed {
      cmd_type     command;
      logic [15:0] cluster_id;
      logic [7:0]  src_endpoint;
      logic [7:0]  dst_endpoint;
      logic [7:0]  addr_mode;
      logic [63:0] dst_address;
      logic [7:0]  cmd_code;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [SLOT_W-1:0] slot;
      logic [7:0]        stored_cmd;
   } rsp_type;

   // one table entry as held in the entry memory
   typedef struct packed {
      logic [15:0] cluster_id;
      logic [7:0]  src_endpoint;
      logic [7:0]  dst_endpoint;
      logic [7:0]  addr_mode;
      logic [63:0] dst_address;
      logic [7:0]  cmd_code;
   } entry_type;

endpackage

FILE: src/pcmt_ram.sv
// generic single-write, single-read ram with registered read data
module pcmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/pending_command_match_table.sv
// pending command match table: top level with entry scan sequencer
//
//   channel   ports                                   transfer when
//   request   start, busy, req_data                   start && !busy
//   response  rsp_strobe, rsp_data                    rsp_strobe (one cycle)
//   config    csr_valid, csr_ready, csr_data          csr_valid && csr_ready
//
// find and delete walk the entries through the entry ram, one read per cycle,
// each compared in the cycle after its read; a find ends early on a hit.
// add walks the valid flags up to the first free slot or the last entry. clear
// answers in the cycle after the transfer. reset clears all valid flags at once
// and restores the short mode code; the response cannot be stalled.
module pending_command_match_table #(
   parameter int ENTRIES = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pcmt_pkg::req_type req_data,
   output logic             rsp_strobe,
   output pcmt_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
   localparam int ENTRY_W = $bits(pcmt_pkg::entry_type);

   pcmt_pkg::state_type state_ff, state_in;
   pcmt_pkg::req_type   req_ff, req_in;
   pcmt_pkg::rsp_type   rsp_ff, rsp_in;
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    chk_idx_ff, chk_idx_in;
   logic                issue_on_ff, issue_on_in;
   logic                chk_on_ff, chk_on_in;
   logic                hit_acc_ff, hit_acc_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]          short_mode_ff, short_mode_in;

   logic                accept;
   logic                done;
   logic                match;
   logic                addr_eq;
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [ENTRY_W-1:0]  ram_rd_data;
   pcmt_pkg::entry_type rd_entry;
   pcmt_pkg::entry_type wr_entry;
   logic [IDX_W-1:0]    slot_idx;
   logic [IDX_W+pcmt_pkg::SLOT_W-1:0] slot_wide;
   logic [pcmt_pkg::SLOT_W-1:0]       slot_bits;

   assign accept    = start && !busy;
   assign busy      = (state_ff != pcmt_pkg::ST_IDLE);
   assign csr_ready = (state_ff == pcmt_pkg::ST_IDLE);

   assign rd_entry = pcmt_pkg::entry_type'(ram_rd_data);

   assign wr_entry.cluster_id   = req_ff.cluster_id;
   assign wr_entry.src_endpoint = req_ff.src_endpoint;
   assign wr_entry.dst_endpoint = req_ff.dst_endpoint;
   assign wr_entry.addr_mode    = req_ff.addr_mode;
   assign wr_entry.dst_address  = req_ff.dst_address;
   assign wr_entry.cmd_code     = req_ff.cmd_code;

   pcmt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   // short mode compares only the group address bits
   always_comb begin
      if (req_ff.addr_mode == short_mode_ff) begin
         addr_eq = (rd_entry.dst_address[pcmt_pkg::SHORT_ADDR_W-1:0] ==
                    req_ff.dst_address[pcmt_pkg::SHORT_ADDR_W-1:0]);
      end else begin
         addr_eq = (rd_entry.dst_address == req_ff.dst_address);
      end
   end

   assign match = chk_on_ff && valid_ff[chk_idx_ff] && addr_eq &&
                  (rd_entry.cluster_id   == req_ff.cluster_id) &&
                  (rd_entry.src_endpoint == req_ff.src_endpoint) &&
                  (rd_entry.dst_endpoint == req_ff.dst_endpoint) &&
                  (rd_entry.addr_mode    == req_ff.addr_mode);

   assign slot_idx  = (req_ff.command == pcmt_pkg::CMD_ADD) ? idx_ff : chk_idx_ff;
   assign slot_wide = {{pcmt_pkg::SLOT_W{1'b0}}, slot_idx};
   assign slot_bits = slot_wide[pcmt_pkg::SLOT_W-1:0];

   always_comb begin
      case (req_ff.command)
         pcmt_pkg::CMD_FIND:   done = chk_on_ff && (match || (chk_idx_ff == LAST_IDX));
         pcmt_pkg::CMD_DELETE: done = chk_on_ff && (chk_idx_ff == LAST_IDX);
         pcmt_pkg::CMD_ADD:    done = !valid_ff[idx_ff] || (idx_ff == LAST_IDX);
         default:              done = 1'b1;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcmt_pkg::ST_IDLE: begin
            if (accept && (req_data.command != pcmt_pkg::CMD_CLEAR)) begin
               state_in = pcmt_pkg::ST_SCAN;
            end
         end
         pcmt_pkg::ST_SCAN: begin
            if (done) begin
               state_in = pcmt_pkg::ST_IDLE;
            end
         end
         default: state_in = pcmt_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in        = req_ff;
      rsp_in        = '0;
      rsp_strobe_in = 1'b0;
      valid_in      = valid_ff;
      idx_in        = idx_ff;
      chk_idx_in    = chk_idx_ff;
      issue_on_in   = issue_on_ff;
      chk_on_in     = 1'b0;
      hit_acc_in    = hit_acc_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      short_mode_in = short_mode_ff;
      case (state_ff)
         pcmt_pkg::ST_IDLE: begin
            if (csr_valid) begin
               short_mode_in = csr_data;
            end
            if (accept) begin
               req_in      = req_data;
               idx_in      = '0;
               hit_acc_in  = 1'b0;
               issue_on_in = (req_data.command == pcmt_pkg::CMD_FIND) ||
                             (req_data.command == pcmt_pkg::CMD_DELETE);
               if (req_data.command == pcmt_pkg::CMD_CLEAR) begin
                  valid_in      = '0;
                  rsp_strobe_in = 1'b1;
               end
            end
         end
         pcmt_pkg::ST_SCAN: begin
            case (req_ff.command)
               pcmt_pkg::CMD_FIND, pcmt_pkg::CMD_DELETE: begin
                  // read one entry per cycle, compare it in the next
                  if (issue_on_ff) begin
                     ram_rd_en  = 1'b1;
                     chk_on_in  = 1'b1;
                     chk_idx_in = idx_ff;
                     if (idx_ff == LAST_IDX) begin
                        issue_on_in = 1'b0;
                     end else begin
                        idx_in = idx_ff + 1'b1;
                     end
                  end
                  if (req_ff.command == pcmt_pkg::CMD_DELETE) begin
                     if (match) begin
                        valid_in[chk_idx_ff] = 1'b0;
                        hit_acc_in           = 1'b1;
                     end
                     rsp_in.ok = hit_acc_ff || match;
                  end else if (match) begin
                     rsp_in.ok         = 1'b1;
                     rsp_in.slot       = slot_bits;
                     rsp_in.stored_cmd = rd_entry.cmd_code;
                  end
               end
               pcmt_pkg::CMD_ADD: begin
                  if (!valid_ff[idx_ff]) begin
                     ram_wr_en        = 1'b1;
                     valid_in[idx_ff] = 1'b1;
                     rsp_in.ok        = 1'b1;
                     rsp_in.slot      = slot_bits;
                  end else if (idx_ff != LAST_IDX) begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               default: begin
                  rsp_in = '0;
               end
            endcase
            if (done) begin
               rsp_strobe_in = 1'b1;
               issue_on_in   = 1'b0;
               chk_on_in     = 1'b0;
            end
         end
         default: begin
            issue_on_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pcmt_pkg::ST_IDLE;
         valid_ff      <= '0;
         issue_on_ff   <= 1'b0;
         chk_on_ff     <= 1'b0;
         hit_acc_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         short_mode_ff <= 8'd1;
         idx_ff        <= '0;
         chk_idx_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         issue_on_ff   <= issue_on_in;
         chk_on_ff     <= chk_on_in;
         hit_acc_ff    <= hit_acc_in;
         rsp_strobe_ff <= rsp_strobe_in;
         short_mode_ff <= short_mode_in;
         idx_ff        <= idx_in;
         chk_idx_ff    <= chk_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

FILE: src/pcmt_checker.sv
// port-level checks for the pending command match table, bound to the top level
module pcmt_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input pcmt_pkg::rsp_type rsp_data
);

   // an accepted command either starts a walk or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted command neither busy nor answered");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while still busy");

   a_busy_ends_in_response: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("walk ended without a response");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.ok) |->
         ((rsp_data.slot == '0) && (rsp_data.stored_cmd == '0)))
      else $error("failed response carries nonzero slot or command");

endmodule

bind pending_command_match_table pcmt_checker u_pcmt_checker (.*);
